/* rtl/zwe_pkg.sv */
// zwe_pkg: shared types, constants and rounding helper for the zernike wavefront unit
// no dependencies; imported by every rtl module of the block

package zwe_pkg;

  localparam int TERM_COUNT    = 21;
  localparam int TERM_SLOTS    = 21;
  localparam int MAX_GRID_LOG2 = 12;
  localparam int MIN_GRID_LOG2 = 4;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

  // inner constants, q20
  localparam int CFocus   = 581383;
  localparam int CComa    = 706526;
  localparam int CSphA    = 1162766;
  localparam int CSphB    = 252962;
  localparam int CSastig  = 787338;
  localparam int C5ComaA  = 1290342;
  localparam int C5ComaB  = 338922;
  localparam int CTref5   = 838966;
  localparam int CSph5A   = 1744149;
  localparam int CSph5B   = 842149;
  localparam int CSph5C   = 109478;

  typedef logic signed [11:0] coord_t;
  typedef logic signed [31:0] pterm_t;
  typedef logic signed [47:0] wide_t;
  typedef logic signed [63:0] dword_t;
  typedef logic signed [23:0] coeff_t;

  // outer normalization constants, q24, terms 2..22
  localparam pterm_t OUTER_K [TERM_SLOTS] = '{
    32'sd31864250,  32'sd31864250,  32'sd65220493,  32'sd38818555,  32'sd38818555,
    32'sd139830762, 32'sd139830762, 32'sd44798004,  32'sd44798004,  32'sd283467489,
    32'sd201891062, 32'sd201891062, 32'sd50082552,  32'sd50082552,  32'sd609372180,
    32'sd609372180, 32'sd274679969, 32'sd274679969, 32'sd54862312,  32'sd54862312,
    32'sd1255346128
  };

  // item tag that travels with the data through every stage
  typedef struct packed {
    logic        vld;
    logic        load;
    logic [4:0]  idx;
    coeff_t      val;
    logic [11:0] row;
    logic [11:0] col;
  } zwe_tag_t;

  // round half up, then floor shift by n
  function automatic dword_t rnd(input dword_t x, input int n);
    dword_t half;
    half = 64'sd1 <<< (n - 1);
    rnd  = (x + half) >>> n;
  endfunction

endpackage

/* rtl/zwe_coord.sv */
// zwe_coord: grid size register and row/column to pupil coordinate mapping
// depends on zwe_pkg

module zwe_coord import zwe_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_grid_size_log2,
  input  logic        accept,
  input  logic        command,
  input  logic [4:0]  coeff_index,
  input  coeff_t      coeff_value,
  input  logic [11:0] grid_row,
  input  logic [11:0] grid_col,
  output zwe_tag_t    tag_o,
  output coord_t      u_o,
  output coord_t      w_o
);

  logic [3:0]  lg_r;
  logic [3:0]  lg_eff;
  logic [3:0]  sh;
  logic [11:0] rb;
  logic [11:0] cb;
  zwe_tag_t    tag_r;
  coord_t      u_r;
  coord_t      w_r;

  always_comb begin
    if (lg_r < 4'(MIN_GRID_LOG2)) begin
      lg_eff = 4'(MIN_GRID_LOG2);
    end else if (lg_r > 4'(MAX_GRID_LOG2)) begin
      lg_eff = 4'(MAX_GRID_LOG2);
    end else begin
      lg_eff = lg_r;
    end
    sh = 4'd12 - lg_eff;
    // shifting drops the bits above the grid size, so the index wraps
    rb = grid_row << sh;
    cb = grid_col << sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lg_r <= 4'd8;
    end else if (cfg_we) begin
      lg_r <= cfg_grid_size_log2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r.vld <= 1'b0;
    end else begin
      tag_r.vld  <= accept;
      tag_r.load <= (command == CMD_LOAD);
      tag_r.idx  <= coeff_index;
      tag_r.val  <= coeff_value;
      tag_r.row  <= grid_row;
      tag_r.col  <= grid_col;
    end
  end

  // subtracting the center is a flip of the top bit
  always_ff @(posedge clk) begin
    u_r <= coord_t'(rb ^ 12'h800);
    w_r <= coord_t'(cb ^ 12'h800);
  end

  assign tag_o = tag_r;
  assign u_o   = u_r;
  assign w_o   = w_r;

endmodule

/* rtl/zwe_poly.sv */
// zwe_poly: five stage pipeline forming the q20 polynomial factor of every term
// depends on zwe_pkg

module zwe_poly import zwe_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  zwe_tag_t tag_i,
  input  coord_t   u_i,
  input  coord_t   w_i,
  output zwe_tag_t tag_o,
  output pterm_t   p_o [TERM_SLOTS]
);

  // stage 1: squares
  zwe_tag_t tag1_r;
  coord_t   u1_r, w1_r;
  logic signed [23:0] uu1_r, ww1_r, uw1_r;

  // stage 2: products of second order terms
  zwe_tag_t tag2_r;
  coord_t   u2_r, w2_r;
  logic signed [24:0] s2_nxt, d2c2_nxt, d2s2_nxt;
  logic signed [24:0] s2_r, d2c2_r, d2s2_r;
  wide_t m_uu2_r, m_uuww_r, m_ww2_r, m_d3c_r, m_d3s_r, m_c5_r, m_c6_r;
  wide_t m_sph_r, m_sac_r, m_sas_r, m_qd_r, m_5c_r, m_s5_r;

  // stage 3: rounded factors
  zwe_tag_t tag3_r;
  coord_t   u3_r, w3_r;
  logic signed [24:0] s3_r;
  pterm_t p3_nxt [14];
  pterm_t p3_r   [14];
  pterm_t q14_nxt, q18_nxt, q19_nxt, q20_nxt, t5_nxt;
  pterm_t q14_r, q18_r, q19_r, q20_r, t5_r;

  // stage 4: fifth order products
  zwe_tag_t tag4_r;
  pterm_t p4_r [14];
  dword_t m14_r, m15_r, m16_r, m17_r, m18_r, m19_r, m20_r;

  // stage 5: finished factors
  zwe_tag_t tag5_r;
  pterm_t p5_r [TERM_SLOTS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r.vld <= 1'b0;
      tag2_r.vld <= 1'b0;
      tag3_r.vld <= 1'b0;
      tag4_r.vld <= 1'b0;
      tag5_r.vld <= 1'b0;
    end else begin
      tag1_r <= tag_i;
      tag2_r <= tag1_r;
      tag3_r <= tag2_r;
      tag4_r <= tag3_r;
      tag5_r <= tag4_r;
    end
  end

  always_ff @(posedge clk) begin
    u1_r  <= u_i;
    w1_r  <= w_i;
    uu1_r <= u_i * u_i;
    ww1_r <= w_i * w_i;
    uw1_r <= u_i * w_i;
  end

  always_comb begin
    s2_nxt   = uu1_r + ww1_r;
    d2c2_nxt = uu1_r - ww1_r;
    d2s2_nxt = uw1_r * 25'sd2;
  end

  always_ff @(posedge clk) begin
    u2_r     <= u1_r;
    w2_r     <= w1_r;
    s2_r     <= s2_nxt;
    d2c2_r   <= d2c2_nxt;
    d2s2_r   <= d2s2_nxt;
    m_uu2_r  <= uu1_r * uu1_r;
    m_uuww_r <= uu1_r * ww1_r;
    m_ww2_r  <= ww1_r * ww1_r;
    m_d3c_r  <= u1_r * (uu1_r - 3 * ww1_r);
    m_d3s_r  <= w1_r * (3 * uu1_r - ww1_r);
    m_c5_r   <= u1_r * (s2_nxt - CComa);
    m_c6_r   <= w1_r * (s2_nxt - CComa);
    m_sph_r  <= s2_nxt * (s2_nxt - CSphA);
    m_sac_r  <= (s2_nxt - CSastig) * d2c2_nxt;
    m_sas_r  <= (s2_nxt - CSastig) * d2s2_nxt;
    m_qd_r   <= uw1_r * d2c2_nxt;
    m_5c_r   <= s2_nxt * (s2_nxt - C5ComaA);
    m_s5_r   <= s2_nxt * (s2_nxt - CSph5A);
  end

  always_comb begin
    p3_nxt[0]  = 32'(u2_r) * 32'sd1024;
    p3_nxt[1]  = 32'(w2_r) * 32'sd1024;
    p3_nxt[2]  = 32'(s2_r) - 32'(CFocus);
    p3_nxt[3]  = 32'(d2c2_r);
    p3_nxt[4]  = 32'(d2s2_r);
    p3_nxt[5]  = 32'(rnd(64'(m_c5_r), 10));
    p3_nxt[6]  = 32'(rnd(64'(m_c6_r), 10));
    p3_nxt[7]  = 32'(rnd(64'(m_d3c_r), 10));
    p3_nxt[8]  = 32'(rnd(64'(m_d3s_r), 10));
    p3_nxt[9]  = 32'(rnd(64'(m_sph_r), 20) + 64'(CSphB));
    p3_nxt[10] = 32'(rnd(64'(m_sac_r), 20));
    p3_nxt[11] = 32'(rnd(64'(m_sas_r), 20));
    p3_nxt[12] = 32'(rnd(64'(m_uu2_r) - 64'sd6 * 64'(m_uuww_r) + 64'(m_ww2_r), 20));
    p3_nxt[13] = 32'(rnd(64'sd4 * 64'(m_qd_r), 20));
    q14_nxt    = 32'(rnd(64'(m_5c_r), 20) + 64'(C5ComaB));
    q18_nxt    = 32'(rnd(64'(m_uu2_r) - 64'sd10 * 64'(m_uuww_r)
                     + 64'sd5 * 64'(m_ww2_r), 20));
    q19_nxt    = 32'(rnd(64'sd5 * 64'(m_uu2_r) - 64'sd10 * 64'(m_uuww_r)
                     + 64'(m_ww2_r), 20));
    q20_nxt    = 32'(rnd(64'(m_s5_r), 20) + 64'(CSph5B));
    t5_nxt     = 32'(s2_r) - 32'(CTref5);
  end

  always_ff @(posedge clk) begin
    u3_r  <= u2_r;
    w3_r  <= w2_r;
    s3_r  <= s2_r;
    p3_r  <= p3_nxt;
    q14_r <= q14_nxt;
    q18_r <= q18_nxt;
    q19_r <= q19_nxt;
    q20_r <= q20_nxt;
    t5_r  <= t5_nxt;
  end

  always_ff @(posedge clk) begin
    p4_r  <= p3_r;
    m14_r <= q14_r * u3_r;
    m15_r <= q14_r * w3_r;
    m16_r <= t5_r * p3_r[7];
    m17_r <= t5_r * p3_r[8];
    m18_r <= q18_r * u3_r;
    m19_r <= q19_r * w3_r;
    m20_r <= q20_r * s3_r;
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 14; k++) begin
      p5_r[k] <= p4_r[k];
    end
    p5_r[14] <= 32'(rnd(m14_r, 10));
    p5_r[15] <= 32'(rnd(m15_r, 10));
    p5_r[16] <= 32'(rnd(m16_r, 20));
    p5_r[17] <= 32'(rnd(m17_r, 20));
    p5_r[18] <= 32'(rnd(m18_r, 10));
    p5_r[19] <= 32'(rnd(m19_r, 10));
    p5_r[20] <= 32'(rnd(m20_r, 20) - 64'(CSph5C));
  end

  assign tag_o = tag5_r;
  assign p_o   = p5_r;

endmodule

/* rtl/zwe_accum.sv */
// zwe_accum: term scaling, coefficient table, weighted sum tree, rounding and clipping
// depends on zwe_pkg

module zwe_accum import zwe_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  zwe_tag_t     tag_i,
  input  pterm_t       p_i [TERM_SLOTS],
  output logic         out_valid,
  output logic [31:0]  out_path_difference,
  output logic [11:0]  out_row,
  output logic [11:0]  out_col,
  output logic         out_saturated
);

  localparam int GroupSize = 6;
  localparam int NumGroups = (TERM_SLOTS + GroupSize - 1) / GroupSize;

  zwe_tag_t tag1_r, tag2_r, tag3_r, tag4_r;
  dword_t   prod1_r [TERM_SLOTS];
  coeff_t   coeff_r [TERM_SLOTS];
  dword_t   term2_r [TERM_SLOTS];
  dword_t   grp3_nxt [NumGroups];
  dword_t   grp3_r   [NumGroups];
  dword_t   sum4_nxt;
  dword_t   sum4_r;
  dword_t   res5;
  logic     valid5_r;
  logic [31:0] pd5_r;
  logic [11:0] row5_r, col5_r;
  logic     sat5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r.vld <= 1'b0;
      tag2_r.vld <= 1'b0;
      tag3_r.vld <= 1'b0;
      tag4_r.vld <= 1'b0;
    end else begin
      tag1_r <= tag_i;
      tag2_r <= tag1_r;
      tag3_r <= tag2_r;
      tag4_r <= tag3_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < TERM_SLOTS; k++) begin
      prod1_r[k] <= p_i[k] * OUTER_K[k];
    end
  end

  // loads write here, in item order with the evaluations reading the table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < TERM_SLOTS; k++) begin
        coeff_r[k] <= '0;
      end
    end else if (tag1_r.vld && tag1_r.load && (tag1_r.idx < 5'(TERM_COUNT))) begin
      for (int k = 0; k < TERM_SLOTS; k++) begin
        if (tag1_r.idx == 5'(k)) begin
          coeff_r[k] <= tag1_r.val;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < TERM_SLOTS; k++) begin
      if (k < TERM_COUNT) begin
        term2_r[k] <= 36'(rnd(prod1_r[k], 28)) * coeff_r[k];
      end else begin
        term2_r[k] <= '0;
      end
    end
  end

  always_comb begin
    for (int g = 0; g < NumGroups; g++) begin
      grp3_nxt[g] = '0;
      for (int j = 0; j < GroupSize; j++) begin
        if (g * GroupSize + j < TERM_SLOTS) begin
          grp3_nxt[g] = grp3_nxt[g] + term2_r[g * GroupSize + j];
        end
      end
    end
  end

  always_comb begin
    sum4_nxt = '0;
    for (int g = 0; g < NumGroups; g++) begin
      sum4_nxt = sum4_nxt + grp3_r[g];
    end
  end

  always_ff @(posedge clk) begin
    grp3_r <= grp3_nxt;
    sum4_r <= sum4_nxt;
  end

  assign res5 = rnd(sum4_r, 16);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid5_r <= 1'b0;
    end else begin
      valid5_r <= tag4_r.vld && !tag4_r.load;
    end
  end

  always_ff @(posedge clk) begin
    row5_r <= tag4_r.row;
    col5_r <= tag4_r.col;
    if (res5 > 64'sd2147483647) begin
      pd5_r  <= 32'h7fff_ffff;
      sat5_r <= 1'b1;
    end else if (res5 < -64'sd2147483648) begin
      pd5_r  <= 32'h8000_0000;
      sat5_r <= 1'b1;
    end else begin
      pd5_r  <= res5[31:0];
      sat5_r <= 1'b0;
    end
  end

  assign out_valid           = valid5_r;
  assign out_path_difference = pd5_r;
  assign out_row             = row5_r;
  assign out_col             = col5_r;
  assign out_saturated       = sat5_r;

endmodule

/* rtl/zernike_wavefront_eval_unit.sv */
// zernike_wavefront_eval_unit: top level of the zernike wavefront evaluator
// depends on zwe_pkg, zwe_coord, zwe_poly, zwe_accum
//
// usage
// - an item is taken at every rising edge with start high and busy low; busy
//   is always low, so a new item may enter in every cycle
// - in_command selects a coefficient load (in_coeff_index, in_coeff_value) or
//   the evaluation of one grid point (in_grid_row, in_grid_col)
// - a load gives no result; its table write takes effect in item order, so
//   evaluations taken after it see the new value and earlier ones do not
// - an evaluation gives one result: out_valid is high for one cycle, with
//   out_path_difference (q15.16), out_row, out_col and out_saturated
// - throughput is one item per clock; the pipeline has one coordinate stage,
//   five polynomial stages and five scaling, weighting and summing stages
// - cfg_we writes cfg_grid_size_log2; write it only while no item is in flight
// - synchronous reset clears the pipeline valid bits and the coefficient
//   table, and sets the grid size to 256
// - the receiver cannot hold results off; none is needed, since nothing
//   stalls

module zernike_wavefront_eval_unit import zwe_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_command,
  input  logic [4:0]  in_coeff_index,
  input  logic signed [23:0] in_coeff_value,
  input  logic [11:0] in_grid_row,
  input  logic [11:0] in_grid_col,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_grid_size_log2,
  output logic        out_valid,
  output logic signed [31:0] out_path_difference,
  output logic [11:0] out_row,
  output logic [11:0] out_col,
  output logic        out_saturated
);

  zwe_tag_t coord_tag;
  coord_t   coord_u;
  coord_t   coord_w;
  zwe_tag_t poly_tag;
  pterm_t   poly_p [TERM_SLOTS];
  logic     accept;
  logic [31:0] pd_bits;

  // fully pipelined, never holds items off
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // grid register and normalization to q10 pupil coordinates
  zwe_coord u_coord (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_grid_size_log2 (cfg_grid_size_log2),
    .accept             (accept),
    .command            (in_command),
    .coeff_index        (in_coeff_index),
    .coeff_value        (in_coeff_value),
    .grid_row           (in_grid_row),
    .grid_col           (in_grid_col),
    .tag_o              (coord_tag),
    .u_o                (coord_u),
    .w_o                (coord_w)
  );

  // exact polynomial forms of r^k cos/sin(m theta)
  zwe_poly u_poly (
    .clk   (clk),
    .rst_n (rst_n),
    .tag_i (coord_tag),
    .u_i   (coord_u),
    .w_i   (coord_w),
    .tag_o (poly_tag),
    .p_o   (poly_p)
  );

  // normalization, coefficient weighting, summation and clipping
  zwe_accum u_accum (
    .clk                 (clk),
    .rst_n               (rst_n),
    .tag_i               (poly_tag),
    .p_i                 (poly_p),
    .out_valid           (out_valid),
    .out_path_difference (pd_bits),
    .out_row             (out_row),
    .out_col             (out_col),
    .out_saturated       (out_saturated)
  );

  assign out_path_difference = signed'(pd_bits);

endmodule
